[hdl/dirty_chunk_bitmap_tracker_macros.svh]
// Assertion shorthands used by the checker file.
// Every assertion samples on the rising clock edge and is off while reset is high.
`ifndef DIRTY_CHUNK_BITMAP_TRACKER_MACROS_SVH
`define DIRTY_CHUNK_BITMAP_TRACKER_MACROS_SVH

// Property that must hold at every edge.
`define DCBT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCBT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/dcbt_pkg.sv]
`default_nettype none

package dcbt_pkg;

   // Field widths of the request, response and register beats
   localparam int OPCODE_W    = 2;
   localparam int SECTOR_W    = 27;
   localparam int COUNT_W     = 17;
   localparam int DISK_W      = 28;
   localparam int SET_COUNT_W = 18;

   // Chunk geometry: chunk size is a power of two, so a sector maps to its chunk by a shift
   localparam int SECTORS_PER_CHUNK = 2048;
   localparam int SECTOR_SHIFT      = $clog2(SECTORS_PER_CHUNK);
   localparam int END_W             = SECTOR_W + 1;
   localparam int CHUNK_W           = END_W - SECTOR_SHIFT;

   // Bitmap word: a power of two wide, so chunk to word and bit is a split of the index
   localparam int WORD_BITS = 64;
   localparam int BIT_W     = $clog2(WORD_BITS);

   // Default store depth per map, in chunks
   localparam int unsigned CHUNKS_PER_MAP_DEF = 65536;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_MARK  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

   // What the back end does with a queued command
   typedef enum logic [1:0] {
      CMD_SET,
      CMD_CLR,
      CMD_QUERY,
      CMD_REPORT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic               sel;
      logic [CHUNK_W-1:0] chunk;
      logic [CHUNK_W-1:0] last;
      logic               err;
      logic               query_ok;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BE_CLEAR,
      BE_IDLE,
      BE_WORK
   } be_state_type;

endpackage

`default_nettype wire

[hdl/dcbt_front.sv]
`default_nettype none

module dcbt_front
   import dcbt_pkg::*;
#(
   parameter int unsigned CHUNKS_PER_MAP = CHUNKS_PER_MAP_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [DISK_W-1:0]      csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [OPCODE_W-1:0]    req_opcode,
   input  wire logic [SECTOR_W-1:0]    req_start_sector,
   input  wire logic [COUNT_W-1:0]     req_sector_count,
   input  wire logic                   req_map_select,
   input  wire queue_status_type       q_status,
   input  wire logic                   clearing,
   output logic                        push,
   output cmd_type                     push_cmd
);

   logic [DISK_W-1:0]  disk_ff;
   logic [DISK_W-1:0]  disk_in;
   logic [END_W-1:0]   end_sector;
   logic [CHUNK_W-1:0] first_chunk;
   logic [CHUNK_W-1:0] last_chunk;
   logic               past_store;
   logic               query_ok;

   // Disk size register
   always_comb begin
      disk_in = disk_ff;
      if (csr_we) begin
         disk_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_ff <= '0;
      end else begin
         disk_ff <= disk_in;
      end
   end

   // Chunk span of the range and its bounds checks
   always_comb begin
      end_sector  = END_W'(req_start_sector) + END_W'(req_sector_count) - END_W'(1);
      first_chunk = CHUNK_W'(req_start_sector >> SECTOR_SHIFT);
      last_chunk  = end_sector[END_W-1:SECTOR_SHIFT];
      past_store  = 32'(last_chunk) >= CHUNKS_PER_MAP;
      query_ok    = (DISK_W'(req_start_sector) < disk_ff)
                    && (32'(first_chunk) < CHUNKS_PER_MAP);
   end

   // Classify the beat into a back-end command
   always_comb begin
      push_cmd.sel      = req_map_select;
      push_cmd.chunk    = first_chunk;
      push_cmd.last     = last_chunk;
      push_cmd.err      = 1'b0;
      push_cmd.query_ok = query_ok;
      push_cmd.kind     = CMD_REPORT;
      case (req_opcode)
         OP_MARK, OP_CLEAR: begin
            if (req_sector_count != '0) begin
               if (past_store) begin
                  push_cmd.err = 1'b1;
               end else begin
                  push_cmd.kind = (req_opcode == OP_MARK) ? CMD_SET : CMD_CLR;
               end
            end
         end
         OP_QUERY: begin
            push_cmd.kind = CMD_QUERY;
         end
         default: begin
            push_cmd.kind = CMD_REPORT;
         end
      endcase
   end

   // Take a beat whenever the queue has room and the store is not being swept
   assign req_ready = !q_status.full && !clearing;
   assign push      = req_valid && req_ready;

endmodule

`default_nettype wire

[hdl/dcbt_queue.sv]
`default_nettype none

module dcbt_queue
   import dcbt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire cmd_type    push_cmd,
   input  wire logic       pop,
   output cmd_type         head,
   output queue_status_type status
);

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff;
   logic [QFILL_W-1:0]   fill_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + QPTR_W'(1);
   endfunction

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QFILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);

endmodule

`default_nettype wire

[hdl/dcbt_back.sv]
`default_nettype none

module dcbt_back
   import dcbt_pkg::*;
#(
   parameter int unsigned CHUNKS_PER_MAP = CHUNKS_PER_MAP_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                head,
   input  wire queue_status_type       q_status,
   output logic                        pop,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_dirty_bit,
   output logic [SET_COUNT_W-1:0]      rsp_set_count,
   output logic                        rsp_range_error
);

   localparam int unsigned WORDS_PER_MAP = (CHUNKS_PER_MAP + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned STORE_WORDS   = 2 * WORDS_PER_MAP;
   localparam int          ADDR_W        = $clog2(STORE_WORDS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_WORDS - 1);

   logic [WORD_BITS-1:0]   mem [STORE_WORDS];
   logic [WORD_BITS-1:0]   rdata_ff;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [WORD_BITS-1:0]   mem_wdata;
   logic                   mem_re;
   logic [ADDR_W-1:0]      mem_raddr;

   be_state_type           state_ff;
   be_state_type           state_in;
   logic [ADDR_W-1:0]      clr_addr_ff;
   logic [ADDR_W-1:0]      clr_addr_in;
   cmd_type                cur_ff;
   cmd_type                cur_in;
   logic [WORD_BITS-1:0]   word_ff;
   logic [WORD_BITS-1:0]   word_in;
   logic                   fresh_ff;
   logic                   fresh_in;
   logic [SET_COUNT_W-1:0] count_ff;
   logic [SET_COUNT_W-1:0] count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_dirty_ff;
   logic                   rsp_dirty_in;
   logic [SET_COUNT_W-1:0] rsp_count_ff;
   logic [SET_COUNT_W-1:0] rsp_count_in;
   logic                   rsp_err_ff;
   logic                   rsp_err_in;

   logic [WORD_BITS-1:0]   src_word;
   logic [WORD_BITS-1:0]   mod_word;
   logic [BIT_W-1:0]       bit_idx;
   logic                   old_bit;
   logic                   out_free;
   logic [CHUNK_W-1:0]     next_chunk;

   function automatic logic [ADDR_W-1:0] word_addr(input logic sel,
                                                    input logic [CHUNK_W-1:0] chunk);
      logic [CHUNK_W-BIT_W-1:0] widx;
      widx = chunk[CHUNK_W-1:BIT_W];
      if (sel) begin
         return ADDR_W'(32'(WORDS_PER_MAP) + 32'(widx));
      end
      return ADDR_W'(32'(widx));
   endfunction

   // Bitmap store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // Word under update and the bit for the current chunk
   always_comb begin
      src_word   = fresh_ff ? rdata_ff : word_ff;
      bit_idx    = cur_ff.chunk[BIT_W-1:0];
      old_bit    = src_word[bit_idx];
      mod_word   = src_word;
      mod_word[bit_idx] = (cur_ff.kind == CMD_SET);
      next_chunk = cur_ff.chunk + CHUNK_W'(1);
      out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Sequencer: sweep after reset, then one word read and one chunk per cycle
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cur_in       = cur_ff;
      word_in      = word_ff;
      fresh_in     = fresh_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dirty_in = rsp_dirty_ff;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;
      mem_we       = 1'b0;
      mem_waddr    = word_addr(cur_ff.sel, cur_ff.chunk);
      mem_wdata    = mod_word;
      mem_re       = 1'b0;
      mem_raddr    = word_addr(head.sel, head.chunk);
      pop          = 1'b0;
      case (state_ff)
         BE_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = BE_IDLE;
            end
         end
         BE_IDLE: begin
            if (!q_status.empty && out_free) begin
               pop    = 1'b1;
               cur_in = head;
               if (head.kind == CMD_REPORT) begin
                  rsp_valid_in = 1'b1;
                  rsp_dirty_in = 1'b0;
                  rsp_count_in = count_ff;
                  rsp_err_in   = head.err;
               end else begin
                  mem_re   = 1'b1;
                  fresh_in = 1'b1;
                  state_in = BE_WORK;
               end
            end
         end
         BE_WORK: begin
            if (cur_ff.kind == CMD_QUERY) begin
               rsp_valid_in = 1'b1;
               rsp_dirty_in = old_bit && cur_ff.query_ok;
               rsp_count_in = count_ff;
               rsp_err_in   = 1'b0;
               state_in     = BE_IDLE;
            end else begin
               // Count only bits that actually flip
               if ((cur_ff.kind == CMD_SET) && !old_bit) begin
                  count_in = count_ff + SET_COUNT_W'(1);
               end else if ((cur_ff.kind == CMD_CLR) && old_bit) begin
                  count_in = count_ff - SET_COUNT_W'(1);
               end
               cur_in.chunk = next_chunk;
               if (cur_ff.chunk == cur_ff.last) begin
                  mem_we       = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_dirty_in = 1'b0;
                  rsp_count_in = count_in;
                  rsp_err_in   = 1'b0;
                  state_in     = BE_IDLE;
               end else if (bit_idx == BIT_W'(WORD_BITS - 1)) begin
                  // Write back this word and fetch the next one
                  mem_we    = 1'b1;
                  mem_re    = 1'b1;
                  mem_raddr = word_addr(cur_ff.sel, next_chunk);
                  fresh_in  = 1'b1;
               end else begin
                  word_in  = mod_word;
                  fresh_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = BE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      word_ff      <= word_in;
      fresh_ff     <= fresh_in;
      rsp_dirty_ff <= rsp_dirty_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign clearing        = (state_ff == BE_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dirty_bit   = rsp_dirty_ff;
   assign rsp_set_count   = rsp_count_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

`default_nettype wire

[hdl/dirty_chunk_bitmap_tracker.sv]
// Channel   Direction  Handshake              Beat contents
// req       in         req_valid/req_ready    opcode, start sector, sector count, map select
// rsp       out        rsp_valid/rsp_ready    dirty bit, set count, range error
// csr       in         csr_we                 disk size in sectors
//
// A mark or clear in the back end first does the registered read of the first bitmap
// word, then handles one chunk per cycle on that word, with the next word read in the
// cycle that writes the previous one back. A query answers after its word read; a refused
// range and an empty range answer without one. Reset clears both maps by a sweep over all
// 2 * ceil(CHUNKS_PER_MAP / 64) store words (2048 by default); req_ready is low meanwhile.
// A two-beat command queue and the response register let either side stall alone.
`default_nettype none

module dirty_chunk_bitmap_tracker
   import dcbt_pkg::*;
#(
   parameter int unsigned CHUNKS_PER_MAP = CHUNKS_PER_MAP_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [DISK_W-1:0]      csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [OPCODE_W-1:0]    req_opcode,
   input  wire logic [SECTOR_W-1:0]    req_start_sector,
   input  wire logic [COUNT_W-1:0]     req_sector_count,
   input  wire logic                   req_map_select,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_dirty_bit,
   output logic [SET_COUNT_W-1:0]      rsp_set_count,
   output logic                        rsp_range_error
);

   queue_status_type q_status;
   logic             clearing;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          head;

   dcbt_front #(
      .CHUNKS_PER_MAP(CHUNKS_PER_MAP)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_start_sector (req_start_sector),
      .req_sector_count (req_sector_count),
      .req_map_select   (req_map_select),
      .q_status         (q_status),
      .clearing         (clearing),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   dcbt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   dcbt_back #(
      .CHUNKS_PER_MAP(CHUNKS_PER_MAP)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_status        (q_status),
      .pop             (pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dirty_bit   (rsp_dirty_bit),
      .rsp_set_count   (rsp_set_count),
      .rsp_range_error (rsp_range_error)
   );

endmodule

`default_nettype wire

[hdl/dcbt_checker.sv]
`default_nettype none
`include "dirty_chunk_bitmap_tracker_macros.svh"

module dcbt_checker
   import dcbt_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic                   rsp_dirty_bit,
   input wire logic [SET_COUNT_W-1:0] rsp_set_count,
   input wire logic                   rsp_range_error
);

   // Queue slots plus the command at work plus the response register
   localparam int MAX_OPEN = QUEUE_DEPTH + 2;
   localparam int OPEN_W   = $clog2(MAX_OPEN + 2);

   logic [OPEN_W-1:0]      open_ff;
   logic [OPEN_W-1:0]      open_in;
   logic                   req_beat;
   logic                   rsp_beat;
   logic                   rsp_stall;
   logic [SET_COUNT_W+1:0] rsp_word;

   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid && rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_dirty_bit, rsp_set_count, rsp_range_error};

   // Track requests taken but not yet answered
   always_comb begin
      open_in = open_ff;
      if (req_beat && !rsp_beat) begin
         open_in = open_ff + OPEN_W'(1);
      end else if (rsp_beat && !req_beat) begin
         open_in = open_ff - OPEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   `DCBT_ASSERT(a_no_invented_rsp, !rsp_valid || (open_ff != '0), "response without request")
   `DCBT_ASSERT(a_open_bounded, open_ff <= OPEN_W'(MAX_OPEN), "too many requests in flight")
   `DCBT_ASSERT(a_err_not_dirty, !(rsp_beat && rsp_range_error && rsp_dirty_bit), "error, dirty")
   `DCBT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "stalled beat changed")

endmodule

bind dirty_chunk_bitmap_tracker dcbt_checker u_checker (.*);

`default_nettype wire
